[sv/uirs_pkg.sv]
// Shared types, constants and handshake structs of the update image receive sequencer.
`default_nettype none
package uirs_pkg;

  localparam int unsigned VER_W      = 8;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned BATT_W     = 7;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned PCT_W      = 7;
  localparam int unsigned PROD_W     = WORD_W + PCT_W;
  localparam int unsigned DIV_STEPS  = PCT_W;
  localparam int unsigned CNT_W      = $clog2(DIV_STEPS);
  localparam int unsigned IN_DATA_W  = 136;
  localparam int unsigned IN_USER_W  = 4;
  localparam int unsigned OUT_DATA_W = 80;
  localparam int unsigned CFG_ADDR_W = 1;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [PCT_W-1:0]  PCT_FULL     = 7'd100;
  localparam logic [BATT_W-1:0] RST_MIN_BATT = 7'd20;
  localparam logic [WORD_W-1:0] RST_GAP_MS   = 32'd5000;
  localparam logic [WORD_W-1:0] RST_BUILD    = 32'd1;

  localparam int unsigned DEF_MAJOR = 1;
  localparam int unsigned DEF_MINOR = 0;
  localparam int unsigned DEF_PATCH = 0;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_INIT   = 3'd1,
    PH_RECV   = 3'd2,
    PH_VALID  = 3'd3,
    PH_FAILED = 3'd4,
    PH_DONE   = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    ACT_SET_VERSION = 3'd0,
    ACT_CAN_START   = 3'd1,
    ACT_START       = 3'd2,
    ACT_PACKET_BYTE = 3'd3,
    ACT_VALIDATE    = 3'd4,
    ACT_COMPLETE    = 3'd5
  } act_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_MIN_BATT  = 1'b0,
    CFG_GAP_LIMIT = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_MUL,
    S_DIV,
    S_DONE
  } ctrl_state_t;

  // input item as packed in in_tdata, first field highest
  typedef struct packed {
    logic [BATT_W-1:0] battery_percent;
    logic [WORD_W-1:0] time_ms;
    logic [BYTE_W-1:0] data_byte;
    logic [WORD_W-1:0] image_size;
    logic [WORD_W-1:0] new_build;
    logic [VER_W-1:0]  new_patch;
    logic [VER_W-1:0]  new_minor;
    logic [VER_W-1:0]  new_major;
  } in_item_t;

  // result item as packed in out_tdata, first field highest
  typedef struct packed {
    logic              image_approved;
    logic [BYTE_W-1:0] packet_check;
    logic [WORD_W-1:0] cur_build;
    logic [VER_W-1:0]  cur_patch;
    logic [VER_W-1:0]  cur_minor;
    logic [VER_W-1:0]  cur_major;
    logic [PCT_W-1:0]  progress_percent;
    logic [2:0]        phase;
    logic              accepted;
  } out_item_t;

  typedef struct packed {
    logic take_item;
    logic exec;
    logic div_load;
    logic div_step;
    logic out_load;
  } uirs_cmd_t;

  typedef struct packed {
    logic out_free;
  } uirs_sts_t;

endpackage
`default_nettype wire

[sv/uirs_ctrl.sv]
// Sequencing state machine: accept, execute, progress division, result hand-off.
`default_nettype none
module uirs_ctrl
  import uirs_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_tvalid,
  output logic           in_tready,
  input  wire uirs_sts_t sts,
  output uirs_cmd_t      cmd
);

  ctrl_state_t       state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.take_item = 1'b1;
          state_nxt     = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.div_load = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DONE: begin
        // wait for the output register to drain
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_EXEC))
    else $error("accepted item not executed next cycle");

  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (cnt_r < CNT_W'(DIV_STEPS)))
    else $error("division step count overran");

endmodule
`default_nettype wire

[sv/uirs_dp.sv]
// Datapath: config and sequencer state registers, action logic, progress divider, output register.
`default_nettype none
module uirs_dp
  import uirs_pkg::*;
#(
  parameter int unsigned DEFAULT_MAJOR = DEF_MAJOR,
  parameter int unsigned DEFAULT_MINOR = DEF_MINOR,
  parameter int unsigned DEFAULT_PATCH = DEF_PATCH
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  input  wire logic [IN_USER_W-1:0]  in_tuser,
  input  wire logic                  in_tlast,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire uirs_cmd_t             cmd,
  output uirs_sts_t                  sts
);

  // configuration
  logic [BATT_W-1:0] min_batt_r;
  logic [WORD_W-1:0] gap_lim_r;

  // latched item
  in_item_t item_r;
  act_t     act_r;
  logic     first_r, last_r;

  // sequencer state
  phase_t            phase_r, phase_nxt;
  logic [VER_W-1:0]  inst_major_r, inst_major_nxt;
  logic [VER_W-1:0]  inst_minor_r, inst_minor_nxt;
  logic [VER_W-1:0]  inst_patch_r, inst_patch_nxt;
  logic [WORD_W-1:0] inst_build_r, inst_build_nxt;
  logic [VER_W-1:0]  pend_major_r, pend_major_nxt;
  logic [VER_W-1:0]  pend_minor_r, pend_minor_nxt;
  logic [VER_W-1:0]  pend_patch_r, pend_patch_nxt;
  logic [WORD_W-1:0] pend_build_r, pend_build_nxt;
  logic [WORD_W-1:0] exp_size_r, exp_size_nxt;
  logic [WORD_W-1:0] rx_count_r, rx_count_nxt;
  logic [WORD_W-1:0] last_time_r, last_time_nxt;
  logic [BYTE_W-1:0] check_r, check_nxt;
  logic              approved_r, approved_nxt;
  logic              rejected_r, rejected_nxt;
  logic              ok_r, ok_nxt;

  // divider
  logic [PROD_W-1:0] rem_r, rem_nxt;
  logic [PROD_W-1:0] den_r, den_nxt;
  logic [PCT_W-1:0]  quo_r, quo_nxt;
  logic              zero_r, zero_nxt;
  logic              full_r, full_nxt;

  // output register
  logic      out_valid_r;
  out_item_t out_r;

  logic              open_phase, gap_late, newer, take;
  logic [WORD_W-1:0] gap_ms, rx_inc;
  logic [PROD_W-1:0] rx_ext, rem_diff;
  logic [PCT_W-1:0]  pct;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_batt_r <= RST_MIN_BATT;
      gap_lim_r  <= RST_GAP_MS;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_MIN_BATT:  min_batt_r <= cfg_wdata[BATT_W-1:0];
        CFG_GAP_LIMIT: gap_lim_r  <= cfg_wdata[WORD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      item_r  <= in_item_t'(in_tdata[$bits(in_item_t)-1:0]);
      act_r   <= act_t'(in_tuser[2:0]);
      first_r <= in_tuser[3];
      last_r  <= in_tlast;
    end
  end

  assign open_phase = (phase_r == PH_INIT) || (phase_r == PH_RECV);
  assign gap_ms     = item_r.time_ms - last_time_r;
  assign gap_late   = gap_ms > gap_lim_r;
  assign newer      = {item_r.new_major, item_r.new_minor, item_r.new_patch} >
                      {inst_major_r, inst_minor_r, inst_patch_r};
  assign rx_inc     = (rx_count_r == '1) ? rx_count_r : rx_count_r + 1'b1;

  always_comb begin
    phase_nxt      = phase_r;
    inst_major_nxt = inst_major_r;
    inst_minor_nxt = inst_minor_r;
    inst_patch_nxt = inst_patch_r;
    inst_build_nxt = inst_build_r;
    pend_major_nxt = pend_major_r;
    pend_minor_nxt = pend_minor_r;
    pend_patch_nxt = pend_patch_r;
    pend_build_nxt = pend_build_r;
    exp_size_nxt   = exp_size_r;
    rx_count_nxt   = rx_count_r;
    last_time_nxt  = last_time_r;
    check_nxt      = check_r;
    approved_nxt   = approved_r;
    rejected_nxt   = rejected_r;
    ok_nxt         = ok_r;
    take           = 1'b0;
    if (cmd.exec) begin
      ok_nxt = 1'b0;
      case (act_r)
        ACT_SET_VERSION: begin
          inst_major_nxt = item_r.new_major;
          inst_minor_nxt = item_r.new_minor;
          inst_patch_nxt = item_r.new_patch;
          inst_build_nxt = inst_build_r + 1'b1;
          ok_nxt         = 1'b1;
        end
        ACT_CAN_START: begin
          ok_nxt = (item_r.battery_percent >= min_batt_r) && (phase_r == PH_IDLE);
        end
        ACT_START: begin
          if (newer) begin
            pend_major_nxt = item_r.new_major;
            pend_minor_nxt = item_r.new_minor;
            pend_patch_nxt = item_r.new_patch;
            pend_build_nxt = item_r.new_build;
            exp_size_nxt   = item_r.image_size;
            rx_count_nxt   = '0;
            phase_nxt      = PH_INIT;
            rejected_nxt   = 1'b0;
            ok_nxt         = 1'b1;
          end
        end
        ACT_PACKET_BYTE: begin
          if (first_r) begin
            if (!open_phase) begin
              rejected_nxt = 1'b1;
            end else if ((phase_r == PH_RECV) && gap_late) begin
              phase_nxt    = PH_FAILED;
              rejected_nxt = 1'b1;
            end else begin
              rejected_nxt = 1'b0;
              check_nxt    = item_r.data_byte;
              take         = 1'b1;
            end
          end else if (open_phase && !rejected_r) begin
            check_nxt = check_r ^ item_r.data_byte;
            take      = 1'b1;
          end
          if (take) begin
            rx_count_nxt = rx_inc;
            if (last_r) begin
              last_time_nxt = item_r.time_ms;
              phase_nxt     = (rx_inc >= exp_size_r) ? PH_VALID : PH_RECV;
            end
          end
          ok_nxt = take;
        end
        ACT_VALIDATE: begin
          if (phase_r == PH_VALID) begin
            if (rx_count_r >= exp_size_r) begin
              approved_nxt = 1'b1;
              ok_nxt       = 1'b1;
            end else begin
              phase_nxt = PH_FAILED;
            end
          end
        end
        ACT_COMPLETE: begin
          if ((phase_r == PH_VALID) && approved_r) begin
            inst_major_nxt = pend_major_r;
            inst_minor_nxt = pend_minor_r;
            inst_patch_nxt = pend_patch_r;
            inst_build_nxt = pend_build_r;
            phase_nxt      = PH_DONE;
            ok_nxt         = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      inst_major_r <= VER_W'(DEFAULT_MAJOR);
      inst_minor_r <= VER_W'(DEFAULT_MINOR);
      inst_patch_r <= VER_W'(DEFAULT_PATCH);
      inst_build_r <= RST_BUILD;
      pend_major_r <= '0;
      pend_minor_r <= '0;
      pend_patch_r <= '0;
      pend_build_r <= '0;
      exp_size_r   <= '0;
      rx_count_r   <= '0;
      last_time_r  <= '0;
      check_r      <= '0;
      approved_r   <= 1'b0;
      rejected_r   <= 1'b0;
      ok_r         <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      inst_major_r <= inst_major_nxt;
      inst_minor_r <= inst_minor_nxt;
      inst_patch_r <= inst_patch_nxt;
      inst_build_r <= inst_build_nxt;
      pend_major_r <= pend_major_nxt;
      pend_minor_r <= pend_minor_nxt;
      pend_patch_r <= pend_patch_nxt;
      pend_build_r <= pend_build_nxt;
      exp_size_r   <= exp_size_nxt;
      rx_count_r   <= rx_count_nxt;
      last_time_r  <= last_time_nxt;
      check_r      <= check_nxt;
      approved_r   <= approved_nxt;
      rejected_r   <= rejected_nxt;
      ok_r         <= ok_nxt;
    end
  end

  // restoring division of count*100 by size, one quotient bit per step;
  // the quotient is used only when count < size, so it fits 7 bits
  assign rx_ext   = PROD_W'(rx_count_r);
  assign rem_diff = rem_r - den_r;

  always_comb begin
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    zero_nxt = zero_r;
    full_nxt = full_r;
    if (cmd.div_load) begin
      // x*100 = x*64 + x*32 + x*4
      rem_nxt  = (rx_ext << 6) + (rx_ext << 5) + (rx_ext << 2);
      den_nxt  = PROD_W'(exp_size_r) << (DIV_STEPS - 1);
      quo_nxt  = '0;
      zero_nxt = (exp_size_r == '0);
      full_nxt = (rx_count_r >= exp_size_r);
    end else if (cmd.div_step) begin
      if (rem_r >= den_r) begin
        rem_nxt = rem_diff;
        quo_nxt = {quo_r[PCT_W-2:0], 1'b1};
      end else begin
        quo_nxt = {quo_r[PCT_W-2:0], 1'b0};
      end
      den_nxt = den_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    quo_r  <= quo_nxt;
    zero_r <= zero_nxt;
    full_r <= full_nxt;
  end

  assign pct = zero_r ? '0 : (full_r ? PCT_FULL : quo_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.accepted         <= ok_r;
      out_r.phase            <= phase_r;
      out_r.progress_percent <= pct;
      out_r.cur_major        <= inst_major_r;
      out_r.cur_minor        <= inst_minor_r;
      out_r.cur_patch        <= inst_patch_r;
      out_r.cur_build        <= inst_build_r;
      out_r.packet_check     <= check_r;
      out_r.image_approved   <= approved_r;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = OUT_DATA_W'(out_r);
  assign sts.out_free = !out_valid_r || out_tready;

  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.progress_percent <= PCT_FULL))
    else $error("progress above full scale");

  a_approve_phase: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(approved_r) |-> ($past(phase_r) == PH_VALID))
    else $error("image approved outside validation");

  a_done_install: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(phase_r == PH_DONE) |-> (inst_build_r == pend_build_r))
    else $error("completion without installing pending build");

endmodule
`default_nettype wire

[sv/update_image_receive_sequencer.sv]
// Top level of the update image receive sequencer: controller plus datapath.
`default_nettype none
// Takes one action item at a time (set version, can-start check, start, packet byte,
// validate, complete) and returns one status item for each. An item occupies the block,
// when the result side is free, through accept, execute, a multiply by 100, seven
// steps of the restoring divider that yields the progress percent, then the load of the
// output register. The divider yields one quotient bit per cycle. The next
// item may be taken while the previous result still waits in the output register.
// Configuration writes are taken at any time but belong to idle periods.
module update_image_receive_sequencer
  import uirs_pkg::*;
#(
  parameter int unsigned DEFAULT_MAJOR = DEF_MAJOR,
  parameter int unsigned DEFAULT_MINOR = DEF_MINOR,
  parameter int unsigned DEFAULT_PATCH = DEF_PATCH
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // new_major, new_minor, new_patch, new_build, image_size, data_byte, time_ms,
  // battery_percent, one zero pad bit
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // action, first_of_packet
  input  wire logic [IN_USER_W-1:0]  in_tuser,
  input  wire logic                  in_tlast,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // accepted, phase, progress_percent, cur_major, cur_minor, cur_patch, cur_build,
  // packet_check, image_approved, four zero pad bits
  output logic [OUT_DATA_W-1:0]      out_tdata,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  uirs_cmd_t cmd;
  uirs_sts_t sts;

  uirs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  uirs_dp #(
    .DEFAULT_MAJOR (DEFAULT_MAJOR),
    .DEFAULT_MINOR (DEFAULT_MINOR),
    .DEFAULT_PATCH (DEFAULT_PATCH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule
`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for the update image receive sequencer.
`default_nettype none
module tb_top;
  import uirs_pkg::*;

  localparam int unsigned ITEMS_PER_PHASE = 350;
  localparam int unsigned NUM_PHASES      = 5;
  localparam int unsigned HOLD_CYCLES     = 400;
  localparam int unsigned SETTLE_CYCLES   = 40;
  localparam logic [2:0]  ACT_SPARE_LO    = 3'd6;
  localparam logic [2:0]  ACT_SPARE_HI    = 3'd7;

  typedef struct {
    logic [2:0] action;
    logic       first_b;
    logic       last_b;
    in_item_t   f;
  } update_req_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic [IN_USER_W-1:0] in_tuser = '0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  update_image_receive_sequencer DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  update_req_t pending_updates[$];
  out_item_t   expected_status[$];

  // shadow of the sequencer state and its registers
  logic [6:0]  min_batt    = RST_MIN_BATT;
  logic [31:0] gap_limit   = RST_GAP_MS;
  phase_t      seq_phase   = PH_IDLE;
  logic [7:0]  inst_maj    = 8'(DEF_MAJOR);
  logic [7:0]  inst_min    = 8'(DEF_MINOR);
  logic [7:0]  inst_pat    = 8'(DEF_PATCH);
  logic [31:0] inst_build  = RST_BUILD;
  logic [7:0]  pend_maj    = '0;
  logic [7:0]  pend_min    = '0;
  logic [7:0]  pend_pat    = '0;
  logic [31:0] pend_build  = '0;
  logic [31:0] image_bytes = '0;
  logic [31:0] rx_count    = '0;
  logic [31:0] last_pkt_ms = '0;
  logic [7:0]  xor_acc     = '0;
  logic        approved    = 1'b0;
  logic        pkt_rej     = 1'b0;

  int unsigned fault_count    = 0;
  int unsigned accepted_items = 0;
  logic        in_fired       = 1'b0;
  logic        hold_off       = 1'b0;
  int unsigned tx_burst       = 1;
  int unsigned tx_gap         = 0;
  int unsigned rx_mode        = 0;
  int unsigned rx_mode_left   = 0;
  int unsigned rx_tick        = 0;
  out_item_t   seen_status;
  out_item_t   want_status;
  out_item_t   pred_status;

  task automatic predict_status(input update_req_t r, output out_item_t res);
    logic              ok;
    logic              open_ph;
    logic [31:0]       since_ms;
    longint unsigned   pct;
    ok = 1'b0;
    case (r.action)
      ACT_SET_VERSION: begin
        inst_maj   = r.f.new_major;
        inst_min   = r.f.new_minor;
        inst_pat   = r.f.new_patch;
        inst_build = inst_build + 32'd1;
        ok = 1'b1;
      end
      ACT_CAN_START: ok = (r.f.battery_percent >= min_batt) && (seq_phase == PH_IDLE);
      ACT_START: begin
        if ({r.f.new_major, r.f.new_minor, r.f.new_patch} > {inst_maj, inst_min, inst_pat}) begin
          pend_maj    = r.f.new_major;
          pend_min    = r.f.new_minor;
          pend_pat    = r.f.new_patch;
          pend_build  = r.f.new_build;
          image_bytes = r.f.image_size;
          rx_count    = '0;
          seq_phase   = PH_INIT;
          pkt_rej     = 1'b0;
          ok = 1'b1;
        end
      end
      ACT_PACKET_BYTE: begin
        open_ph  = (seq_phase == PH_INIT) || (seq_phase == PH_RECV);
        since_ms = r.f.time_ms - last_pkt_ms;
        ok = 1'b1;
        if (r.first_b) begin
          if (!open_ph) begin
            pkt_rej = 1'b1;
            ok = 1'b0;
          end else if (seq_phase == PH_RECV && since_ms > gap_limit) begin
            seq_phase = PH_FAILED;
            pkt_rej = 1'b1;
            ok = 1'b0;
          end else begin
            pkt_rej = 1'b0;
            xor_acc = r.f.data_byte;
          end
        end else if (!open_ph || pkt_rej) begin
          ok = 1'b0;
        end else begin
          xor_acc = xor_acc ^ r.f.data_byte;
        end
        if (ok) begin
          if (rx_count != '1) rx_count = rx_count + 32'd1;
          if (r.last_b) begin
            last_pkt_ms = r.f.time_ms;
            seq_phase = (rx_count >= image_bytes) ? PH_VALID : PH_RECV;
          end
        end
      end
      ACT_VALIDATE: begin
        if (seq_phase == PH_VALID) begin
          if (rx_count >= image_bytes) begin
            approved = 1'b1;
            ok = 1'b1;
          end else begin
            seq_phase = PH_FAILED;
          end
        end
      end
      ACT_COMPLETE: begin
        if (seq_phase == PH_VALID && approved) begin
          inst_maj   = pend_maj;
          inst_min   = pend_min;
          inst_pat   = pend_pat;
          inst_build = pend_build;
          seq_phase  = PH_DONE;
          ok = 1'b1;
        end
      end
      default: ok = 1'b0;
    endcase
    if (image_bytes == '0) begin
      pct = 0;
    end else begin
      pct = ({32'd0, rx_count} * 64'd100) / {32'd0, image_bytes};
      if (pct > 100) pct = 100;
    end
    res.accepted         = ok;
    res.phase            = seq_phase;
    res.progress_percent = pct[6:0];
    res.cur_major        = inst_maj;
    res.cur_minor        = inst_min;
    res.cur_patch        = inst_pat;
    res.cur_build        = inst_build;
    res.packet_check     = xor_acc;
    res.image_approved   = approved;
  endtask

  function automatic update_req_t noise_req();
    update_req_t r;
    r.action = (($urandom_range(0, 49) == 0) ? ($urandom_range(0, 1) ? ACT_SPARE_LO : ACT_SPARE_HI)
                                              : 3'($urandom_range(0, 5)));
    r.first_b           = 1'($urandom_range(0, 1));
    r.last_b            = 1'($urandom_range(0, 1));
    r.f.new_major       = 8'($urandom);
    r.f.new_minor       = 8'($urandom);
    r.f.new_patch       = 8'($urandom);
    r.f.new_build       = $urandom;
    r.f.image_size      = $urandom;
    r.f.data_byte       = 8'($urandom);
    r.f.time_ms         = $urandom;
    r.f.battery_percent = 7'($urandom_range(0, 100));
    return r;
  endfunction

  function automatic update_req_t act_req(input logic [2:0] act);
    update_req_t r;
    r = noise_req();
    r.action  = act;
    r.first_b = 1'b0;
    r.last_b  = 1'b0;
    return r;
  endfunction

  // one update attempt: set a base version, start a (mostly newer) one, stream packets, mostly finish
  task automatic gen_update_run();
    update_req_t r;
    logic [7:0]  bmaj, bmin, bpat;
    logic [31:0] diff, tlast, tnow;
    int unsigned target, sent, plen, k, sel;
    logic        skip_first;
    bmaj = 8'($urandom_range(0, 254));
    bmin = 8'($urandom_range(0, 254));
    bpat = 8'($urandom_range(0, 254));
    r = act_req(ACT_SET_VERSION);
    r.f.new_major = bmaj;
    r.f.new_minor = bmin;
    r.f.new_patch = bpat;
    pending_updates.push_back(r);
    if ($urandom_range(0, 3) == 0) pending_updates.push_back(act_req(ACT_CAN_START));
    r = act_req(ACT_START);
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      r.f.new_major = bmaj;
      r.f.new_minor = bmin;
      r.f.new_patch = bpat;
    end else if (sel < 4) begin
      r.f.new_major = bmaj + 8'd1;
    end else if (sel < 7) begin
      r.f.new_major = bmaj;
      r.f.new_minor = bmin + 8'd1;
    end else begin
      r.f.new_major = bmaj;
      r.f.new_minor = bmin;
      r.f.new_patch = bpat + 8'd1;
    end
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      r.f.image_size = '0;
      target = $urandom_range(1, 4);
    end else if (sel == 1) begin
      target = $urandom_range(1, 24);
    end else begin
      r.f.image_size = $urandom_range(1, 40);
      target = r.f.image_size + (($urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : 0);
    end
    pending_updates.push_back(r);
    tlast = $urandom;
    sent = 0;
    while (sent < target) begin
      plen = $urandom_range(1, 8);
      skip_first = ($urandom_range(0, 19) == 0);
      sel = $urandom_range(0, 19);
      if (sel == 0 && gap_limit != '1)
        diff = gap_limit + 32'd1 +
               ((gap_limit < 32'h8000_0000) ? 32'($urandom_range(0, 1000)) : 32'd0);
      else if (sel == 1)
        diff = gap_limit;
      else
        diff = $urandom_range(0, (gap_limit < 32'd3000) ? gap_limit : 32'd3000);
      tnow = tlast + diff;
      for (k = 0; k < plen; k++) begin
        r = act_req(ACT_PACKET_BYTE);
        r.first_b   = (k == 0) && !skip_first;
        r.last_b    = (k == plen - 1);
        r.f.time_ms = tnow;
        pending_updates.push_back(r);
        tlast = tnow;
        tnow  = tnow + $urandom_range(0, 4);
      end
      sent += plen;
    end
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      pending_updates.push_back(act_req(ACT_COMPLETE));
      pending_updates.push_back(act_req(ACT_VALIDATE));
      pending_updates.push_back(act_req(ACT_COMPLETE));
    end else if (sel != 1) begin
      pending_updates.push_back(act_req(ACT_VALIDATE));
      if (sel == 2) pending_updates.push_back(act_req(ACT_VALIDATE));
      pending_updates.push_back(act_req(ACT_COMPLETE));
    end
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    if (idx == CFG_MIN_BATT) min_batt = val[6:0];
    else gap_limit = val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait for every item to go through, then let the block fall idle
  task automatic settle();
    while (pending_updates.size() != 0 || expected_status.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_directed();
    update_req_t r;
    logic [31:0] t;
    r = act_req(ACT_CAN_START); r.f.battery_percent = 7'd20; pending_updates.push_back(r);
    r = act_req(ACT_CAN_START); r.f.battery_percent = 7'd19; pending_updates.push_back(r);
    r = act_req(ACT_START);
    r.f.new_major = 8'd1; r.f.new_minor = 8'd0; r.f.new_patch = 8'd0;
    pending_updates.push_back(r);
    r = act_req(ACT_START);
    r.f.new_major = 8'd0; r.f.new_minor = 8'hFF; r.f.new_patch = 8'hFF;
    pending_updates.push_back(r);
    r = act_req(ACT_PACKET_BYTE); r.first_b = 1'b1; pending_updates.push_back(r);
    pending_updates.push_back(act_req(ACT_PACKET_BYTE));
    pending_updates.push_back(act_req(ACT_VALIDATE));
    pending_updates.push_back(act_req(ACT_COMPLETE));
    pending_updates.push_back(act_req(ACT_SPARE_LO));
    pending_updates.push_back(act_req(ACT_SPARE_HI));
    r = act_req(ACT_SET_VERSION);
    r.f.new_major = 8'd0; r.f.new_minor = 8'd0; r.f.new_patch = 8'd0;
    pending_updates.push_back(r);
    r = act_req(ACT_START);
    r.f.new_major = 8'd0; r.f.new_minor = 8'd0; r.f.new_patch = 8'd1;
    r.f.new_build = '1; r.f.image_size = 32'd4;
    pending_updates.push_back(r);
    // two-byte packet ending just below the time wrap, then one at exactly the gap limit
    t = 32'hFFFF_FF00;
    r = act_req(ACT_PACKET_BYTE); r.first_b = 1'b1; r.f.data_byte = 8'hA5; r.f.time_ms = t;
    pending_updates.push_back(r);
    t = t + 32'd2;
    r = act_req(ACT_PACKET_BYTE); r.last_b = 1'b1; r.f.data_byte = 8'h5A; r.f.time_ms = t;
    pending_updates.push_back(r);
    t = t + RST_GAP_MS;
    r = act_req(ACT_PACKET_BYTE); r.first_b = 1'b1; r.last_b = 1'b1; r.f.time_ms = t;
    pending_updates.push_back(r);
    r = act_req(ACT_PACKET_BYTE); r.first_b = 1'b1; r.f.time_ms = t + RST_GAP_MS + 32'd1;
    pending_updates.push_back(r);
    pending_updates.push_back(act_req(ACT_PACKET_BYTE));
    r = act_req(ACT_START);
    r.f.new_major = 8'd0; r.f.new_minor = 8'd1; r.f.new_patch = 8'd0;
    r.f.new_build = '1; r.f.image_size = 32'd2;
    pending_updates.push_back(r);
    r = act_req(ACT_PACKET_BYTE); r.first_b = 1'b1; r.last_b = 1'b1; r.f.data_byte = 8'hFF;
    r.f.time_ms = 32'd10;
    pending_updates.push_back(r);
    // overrun past the announced size: progress clamps at full
    r = act_req(ACT_PACKET_BYTE); r.first_b = 1'b1; r.f.data_byte = 8'h00; r.f.time_ms = 32'd20;
    pending_updates.push_back(r);
    r = act_req(ACT_PACKET_BYTE); r.last_b = 1'b1; r.f.data_byte = 8'h80; r.f.time_ms = 32'd21;
    pending_updates.push_back(r);
    r = act_req(ACT_CAN_START); r.f.battery_percent = 7'd100; pending_updates.push_back(r);
    pending_updates.push_back(act_req(ACT_COMPLETE));
    pending_updates.push_back(act_req(ACT_VALIDATE));
    pending_updates.push_back(act_req(ACT_COMPLETE));
    r = act_req(ACT_SET_VERSION);
    r.f.new_major = 8'hFF; r.f.new_minor = 8'hFF; r.f.new_patch = 8'hFF;
    pending_updates.push_back(r);
    r = act_req(ACT_START);
    r.f.new_major = 8'hFF; r.f.new_minor = 8'hFF; r.f.new_patch = 8'hFF;
    pending_updates.push_back(r);
  endtask

  // sender: bursts of items with random gaps; an offered item is held until taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_fired) begin
      in_tvalid <= 1'b1;
    end else if (tx_gap != 0) begin
      tx_gap = tx_gap - 1;
      in_tvalid <= 1'b0;
    end else if (pending_updates.size() != 0) begin
      in_tvalid <= 1'b1;
      in_tdata  <= {1'b0, pending_updates[0].f};
      in_tuser  <= {pending_updates[0].first_b, pending_updates[0].action};
      in_tlast  <= pending_updates[0].last_b;
      tx_burst = tx_burst - 1;
      if (tx_burst == 0) begin
        tx_burst = $urandom_range(1, 24);
        tx_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      end
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  always @(posedge clk) begin
    in_fired <= in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      predict_status(pending_updates.pop_front(), pred_status);
      expected_status.push_back(pred_status);
      accepted_items <= accepted_items + 1;
    end
  end

  // receiver: stall pattern switches at random among four modes
  always @(negedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_mode_left = $urandom_range(50, 300);
    end else begin
      rx_mode_left = rx_mode_left - 1;
    end
    rx_tick = rx_tick + 1;
    case (rx_mode)
      0: out_tready <= !hold_off;
      1: out_tready <= !hold_off && ($urandom_range(0, 1) == 1);
      2: out_tready <= !hold_off && ($urandom_range(0, 3) == 0);
      default: out_tready <= !hold_off && ((rx_tick % 7) >= 3);
    endcase
  end

  // long stall on the result side while items keep coming, so the input backs up
  initial begin
    while (accepted_items < 150) @(posedge clk);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen_status = out_tdata[$bits(out_item_t)-1:0];
      if (expected_status.size() == 0) begin
        if (fault_count < 10) $display("unexpected status item %h", seen_status);
        fault_count = fault_count + 1;
      end else begin
        want_status = expected_status.pop_front();
        if (seen_status !== want_status) begin
          if (fault_count < 10) begin
            $write("status mismatch: exp ok=%0d ph=%0d pct=%0d ver=%0d.%0d.%0d b=%h chk=%h appr=%0d",
                   want_status.accepted, want_status.phase, want_status.progress_percent,
                   want_status.cur_major, want_status.cur_minor, want_status.cur_patch,
                   want_status.cur_build, want_status.packet_check,
                   want_status.image_approved);
            $display(" / got ok=%0d ph=%0d pct=%0d ver=%0d.%0d.%0d b=%h chk=%h appr=%0d",
                     seen_status.accepted, seen_status.phase, seen_status.progress_percent,
                     seen_status.cur_major, seen_status.cur_minor, seen_status.cur_patch,
                     seen_status.cur_build, seen_status.packet_check,
                     seen_status.image_approved);
          end
          fault_count = fault_count + 1;
        end
      end
    end
  end

  initial begin
    int unsigned ph;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    load_directed();
    settle();
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin write_reg(CFG_MIN_BATT, 32'd0);   write_reg(CFG_GAP_LIMIT, '1); end
        1: begin write_reg(CFG_MIN_BATT, 32'd100); write_reg(CFG_GAP_LIMIT, '0); end
        2: begin
          write_reg(CFG_MIN_BATT, $urandom_range(0, 100));
          write_reg(CFG_GAP_LIMIT, $urandom_range(100, 20000));
        end
        3: begin write_reg(CFG_MIN_BATT, 32'd20);  write_reg(CFG_GAP_LIMIT, 32'd5000); end
        default: begin write_reg(CFG_MIN_BATT, 32'd55); write_reg(CFG_GAP_LIMIT, 32'd1); end
      endcase
      while (pending_updates.size() < ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 99) < 85) gen_update_run();
        else repeat ($urandom_range(1, 5)) pending_updates.push_back(noise_req());
      end
      settle();
    end
    if (expected_status.size() != 0) fault_count = fault_count + 1;
    if (fault_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
`default_nettype wire

[files.f]
sv/uirs_pkg.sv
sv/uirs_ctrl.sv
sv/uirs_dp.sv
sv/update_image_receive_sequencer.sv
tb/tb_top.sv
